[sv/assert_macros.svh]
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASSERT_IMP(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
	else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
	else $error("assertion failed");
`endif

[sv/dmst_pkg.sv]
// types, constants and helpers of the decayed mean spike trigger
`default_nettype none
package dmst_pkg;
	localparam int PENDING_SLOTS = 2;
	localparam int SlotW = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
	localparam int CntW = $clog2(PENDING_SLOTS + 1);

	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_REPORT = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [3:0] ST_ISSUED   = 4'd0;
	localparam logic [3:0] ST_PRIMED   = 4'd1;
	localparam logic [3:0] ST_BACKWARD = 4'd2;
	localparam logic [3:0] ST_BELOW    = 4'd3;
	localparam logic [3:0] ST_DISABLED = 4'd4;
	localparam logic [3:0] ST_LIMIT    = 4'd5;
	localparam logic [3:0] ST_NOTFINAL = 4'd6;
	localparam logic [3:0] ST_RELEASED = 4'd7;
	localparam logic [3:0] ST_UNKNOWN  = 4'd8;
	localparam logic [3:0] ST_CLEARED  = 4'd9;

	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_RATIO  = 2'd1;
	localparam logic [1:0] REG_HALF   = 2'd2;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [31:0]        time_ms;
		logic signed [23:0] sample;
		logic [30:0]        command_id;
		logic signed [31:0] result_value;
	} in_item_t;

	typedef struct packed {
		logic               issued;
		logic [30:0]        new_id;
		logic signed [23:0] new_value;
		logic [3:0]         status;
		logic [1:0]         outstanding_count;
		logic signed [39:0] mean_out;
	} out_item_t;

	// classified item passed from the front to the back
	typedef struct packed {
		logic [1:0]         opcode;
		logic [31:0]        time_ms;
		logic signed [23:0] sample;
		logic [30:0]        command_id;
		logic               final_rep;
	} work_t;

	// 2^(-k/16) in q1.16
	function automatic logic [16:0] pow_tab(input logic [4:0] k);
		case (k)
			5'd0: pow_tab = 17'd65536;
			5'd1: pow_tab = 17'd62757;
			5'd2: pow_tab = 17'd60097;
			5'd3: pow_tab = 17'd57549;
			5'd4: pow_tab = 17'd55109;
			5'd5: pow_tab = 17'd52773;
			5'd6: pow_tab = 17'd50535;
			5'd7: pow_tab = 17'd48393;
			5'd8: pow_tab = 17'd46341;
			5'd9: pow_tab = 17'd44376;
			5'd10: pow_tab = 17'd42495;
			5'd11: pow_tab = 17'd40693;
			5'd12: pow_tab = 17'd38968;
			5'd13: pow_tab = 17'd37316;
			5'd14: pow_tab = 17'd35734;
			5'd15: pow_tab = 17'd34219;
			5'd16: pow_tab = 17'd32768;
			default: pow_tab = 17'd32768;
		endcase
	endfunction
endpackage
`default_nettype wire

[sv/decayed_mean_spike_trigger.sv]
// top level of the decayed mean spike trigger
// A request that is not a sample of a primed mean, or is such a sample with
// a time before the last one, goes from idle straight to the output step;
// any other sample first runs three bit-serial divisions in one shared
// divider. A two-entry queue in front keeps taking requests while the back
// works; one result register holds the answer until popped, and the back
// takes no new request while it is held.
`default_nettype none
module decayed_mean_spike_trigger import dmst_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire in_item_t    in_item,
	output logic             empty,
	input  wire logic        pop,
	output out_item_t        out_item,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	logic        enable_q;
	logic [16:0] ratio_q;
	logic [15:0] half_q;
	logic        wq_valid, wq_take;
	work_t       wq_item;
	out_item_t   res;
	logic [1:0]         u_back_cnt;
	logic signed [39:0] u_back_mean;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			ratio_q <= 17'd68813;
			half_q <= 16'd1000;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_RATIO: ratio_q <= cfg_data[16:0];
				REG_HALF: half_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	dmst_front u_front (
		.clk, .arst_n, .push, .full, .in_item,
		.wq_valid, .wq_item, .wq_take
	);

	dmst_back u_back (
		.clk, .arst_n, .wq_valid, .wq_item, .wq_take,
		.enable_q, .ratio_q, .half_q, .empty, .pop, .res,
		.cnt(u_back_cnt), .mean(u_back_mean)
	);

	dmst_out u_out (
		.raw(res), .cnt(u_back_cnt), .mean(u_back_mean), .res(out_item)
	);
endmodule
`default_nettype wire

[sv/dmst_front.sv]
// front: takes requests, classifies them and queues them for the back
`default_nettype none
module dmst_front import dmst_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	output logic          full,
	input  wire in_item_t in_item,
	output logic          wq_valid,
	output work_t         wq_item,
	input  wire logic     wq_take
);
	`include "assert_macros.svh"

	work_t      mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       acc;

	assign full = (cnt_q == 2'd2);
	assign acc = push && !full;
	assign wq_valid = (cnt_q != 2'd0);
	assign wq_item = mem_q[rd_q];

	// two entry queue storage
	always_ff @(posedge clk) begin
		if (acc) begin
			mem_q[wr_q].opcode <= in_item.opcode;
			mem_q[wr_q].time_ms <= in_item.time_ms;
			mem_q[wr_q].sample <= in_item.sample;
			mem_q[wr_q].command_id <= in_item.command_id;
			mem_q[wr_q].final_rep <= (in_item.result_value <= 32'sd0);
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (acc) wr_q <= ~wr_q;
			if (wq_take) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(acc) - 2'(wq_take);
		end
	end

	`ASSERT_IMP(a_take_nonempty, clk, arst_n, wq_take, wq_valid)
	`ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q != 2'd3)
	`ASSERT_NEXT(a_fill, clk, arst_n, acc && !wq_take, cnt_q == $past(cnt_q) + 2'd1)
endmodule
`default_nettype wire

[sv/dmst_back.sv]
// back: mean update with a shared serial divider, slot bookkeeping and result register
`default_nettype none
module dmst_back import dmst_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wq_valid,
	input  wire work_t       wq_item,
	output logic             wq_take,
	input  wire logic        enable_q,
	input  wire logic [16:0] ratio_q,
	input  wire logic [15:0] half_q,
	output logic             empty,
	input  wire logic        pop,
	output out_item_t        res,
	output logic [1:0]       cnt,
	output logic signed [39:0] mean
);
	`include "assert_macros.svh"

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_DIV1 = 9'b000000010,
		S_DIV2 = 9'b000000100,
		S_DEC  = 9'b000001000,
		S_WMUL = 9'b000010000,
		S_DIFF = 9'b000100000,
		S_DIV3 = 9'b001000000,
		S_MEAN = 9'b010000000,
		S_OUT  = 9'b100000000
	} state_t;

	state_t state_q;
	work_t  it_q;
	logic   primed_q;
	logic [31:0] last_time_q;
	logic signed [39:0] mean_q;
	logic [31:0] wsum_q;
	logic [30:0] idc_q;
	logic [PENDING_SLOTS-1:0] sv_q;
	logic [30:0] sid_q [PENDING_SLOTS];

	// shared restoring divider: 56-bit dividend, 33-bit divisor
	logic [55:0] dvd_q;
	logic [32:0] dvs_q;
	logic [32:0] rem_q;
	logic [5:0]  bit_q;
	logic [33:0] trial;
	logic [32:0] q_dt_q;
	logic [15:0] f_q;
	logic [16:0] dec_q;
	logic [48:0] wd_q;
	logic [32:0] wn_q;
	logic        neg_q;
	logic signed [40:0] diff;
	logic [39:0] mag;
	logic signed [41:0] nm;
	logic signed [39:0] nm_sat;
	logic [3:0]  ib;
	logic [11:0] lb;
	logic [16:0] ta, tb, d;
	logic [28:0] prod;
	logic signed [63:0] lhs;
	logic signed [57:0] rhs;
	logic signed [57:0] rhs_q;
	logic [32:0] dt;
	logic [15:0] hl;

	// result register
	out_item_t res_q;
	logic      full_q;
	logic      out_fire;

	assign empty = !full_q;
	assign res = res_q;
	assign mean = mean_q;
	assign hl = (half_q == 16'd0) ? 16'd1 : half_q;
	assign dt = {1'b0, it_q.time_ms - last_time_q};
	assign trial = {rem_q, dvd_q[55]} - {1'b0, dvs_q};
	assign wq_take = (state_q == S_IDLE) && wq_valid && !full_q;
	assign out_fire = (state_q == S_OUT) && (bit_q != 6'd1);

	// decay interpolation
	assign ib = f_q[15:12];
	assign lb = f_q[11:0];
	assign ta = pow_tab({1'b0, ib});
	assign tb = pow_tab({1'b0, ib} + 5'd1);
	assign prod = 29'(ta - tb) * 29'(lb);
	assign d = ta - 17'(prod >> 12);

	// mean difference and new mean
	assign diff = 41'(it_q.sample) * 41'sd65536 - 41'(mean_q);
	assign mag = diff[40] ? 40'(-diff) : 40'(diff);
	assign nm = neg_q ? 42'(mean_q) - $signed({2'b00, dvd_q[39:0]})
		: 42'(mean_q) + $signed({2'b00, dvd_q[39:0]});
	assign nm_sat = (nm > 42'sd549755813887) ? 40'sh7FFFFFFFFF :
		(nm < -42'sd549755813888) ? 40'sh8000000000 : 40'(nm);
	assign lhs = 64'(it_q.sample) <<< 32;
	assign rhs = 58'(mean_q) * $signed({1'b0, ratio_q});

	// slot helpers
	logic [SlotW-1:0] free_k;
	logic             has_free;
	logic [PENDING_SLOTS-1:0] hit;
	logic [CntW-1:0]  cnt_now;
	always_comb begin
		free_k = '0;
		has_free = 1'b0;
		cnt_now = '0;
		for (int k = PENDING_SLOTS - 1; k >= 0; k--) begin
			if (!sv_q[k]) begin
				free_k = SlotW'(k);
				has_free = 1'b1;
			end
		end
		for (int k = 0; k < PENDING_SLOTS; k++) begin
			hit[k] = sv_q[k] && (sid_q[k] == it_q.command_id);
			cnt_now = cnt_now + CntW'(sv_q[k]);
		end
	end

	// count seen with the waiting result; state stays frozen until it is popped
	assign cnt = 2'(cnt_now);

	// outcome of the request in the final step
	logic [3:0]  st_c;
	logic        do_prime, do_issue, do_free;
	logic [30:0] idc_next;
	assign idc_next = idc_q + 31'd1;
	always_comb begin
		st_c = ST_UNKNOWN;
		do_prime = 1'b0;
		do_issue = 1'b0;
		do_free = 1'b0;
		case (it_q.opcode)
			OP_SAMPLE: begin
				if (!primed_q) begin
					st_c = ST_PRIMED;
					do_prime = 1'b1;
				end else if (it_q.time_ms < last_time_q) begin
					st_c = ST_BACKWARD;
				end else if (lhs < 64'(rhs_q)) begin
					st_c = ST_BELOW;
				end else if (!enable_q) begin
					st_c = ST_DISABLED;
				end else if (!has_free) begin
					st_c = ST_LIMIT;
				end else begin
					st_c = ST_ISSUED;
					do_issue = 1'b1;
				end
			end
			OP_REPORT: begin
				if (!it_q.final_rep) begin
					st_c = ST_NOTFINAL;
				end else if (hit != '0) begin
					st_c = ST_RELEASED;
					do_free = 1'b1;
				end
			end
			OP_CLEAR: begin
				if (hit != '0) begin
					st_c = ST_CLEARED;
					do_free = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// result register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (out_fire) begin
			full_q <= 1'b1;
		end else if (pop) begin
			full_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			it_q <= '0;
			primed_q <= 1'b0;
			last_time_q <= '0;
			mean_q <= '0;
			wsum_q <= '0;
			idc_q <= '0;
			sv_q <= '0;
			sid_q <= '{default: '0};
			dvd_q <= '0;
			dvs_q <= '0;
			rem_q <= '0;
			bit_q <= '0;
			q_dt_q <= '0;
			f_q <= '0;
			dec_q <= '0;
			wd_q <= '0;
			wn_q <= '0;
			neg_q <= 1'b0;
			rhs_q <= '0;
			res_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (wq_take) begin
						it_q <= wq_item;
						if (wq_item.opcode == OP_SAMPLE && primed_q
							&& wq_item.time_ms >= last_time_q) begin
							state_q <= S_DIV1;
							bit_q <= '0;
							rem_q <= '0;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_DIV1: begin
					// dt / h: 32 quotient bits
					if (bit_q == 6'd0) begin
						dvd_q <= {dt[31:0], 24'd0};
						dvs_q <= {17'd0, hl};
						bit_q <= 6'd32;
					end else begin
						if (!trial[33]) begin
							rem_q <= trial[32:0];
							dvd_q <= {dvd_q[54:0], 1'b1};
						end else begin
							rem_q <= {rem_q[31:0], dvd_q[55]};
							dvd_q <= {dvd_q[54:0], 1'b0};
						end
						bit_q <= bit_q - 6'd1;
						if (bit_q == 6'd1) state_q <= S_DIV2;
					end
				end
				S_DIV2: begin
					// (r << 16) / h: 16 quotient bits
					if (bit_q == 6'd0) begin
						q_dt_q <= {1'b0, dvd_q[31:0]};
						dvd_q <= {rem_q[15:0], 40'd0};
						rem_q <= '0;
						bit_q <= 6'd32;
					end else begin
						if (!trial[33]) begin
							rem_q <= trial[32:0];
							dvd_q <= {dvd_q[54:0], 1'b1};
						end else begin
							rem_q <= {rem_q[31:0], dvd_q[55]};
							dvd_q <= {dvd_q[54:0], 1'b0};
						end
						bit_q <= bit_q - 6'd1;
						if (bit_q == 6'd1) state_q <= S_DEC;
					end
				end
				S_DEC: begin
					f_q <= dvd_q[15:0];
					state_q <= S_WMUL;
				end
				S_WMUL: begin
					dec_q <= (q_dt_q >= 33'd17) ? 17'd0 : (d >> q_dt_q[4:0]);
					state_q <= S_DIFF;
					bit_q <= '0;
				end
				S_DIFF: begin
					if (bit_q == 6'd0) begin
						wd_q <= 49'(wsum_q) * 49'(dec_q);
						bit_q <= 6'd63;
					end else begin
						wn_q <= 33'(wd_q >> 16) + 33'd65536;
						neg_q <= diff[40];
						dvd_q <= {mag, 16'd0};
						rem_q <= '0;
						bit_q <= 6'd0;
						state_q <= S_DIV3;
					end
				end
				S_DIV3: begin
					// (|diff| << 16) / w'
					if (bit_q == 6'd0) begin
						dvs_q <= wn_q[32] ? 33'hFFFFFFFF : wn_q;
						wsum_q <= wn_q[32] ? 32'hFFFFFFFF : wn_q[31:0];
						last_time_q <= it_q.time_ms;
						bit_q <= 6'd56;
					end else begin
						if (!trial[33]) begin
							rem_q <= trial[32:0];
							dvd_q <= {dvd_q[54:0], 1'b1};
						end else begin
							rem_q <= {rem_q[31:0], dvd_q[55]};
							dvd_q <= {dvd_q[54:0], 1'b0};
						end
						bit_q <= bit_q - 6'd1;
						if (bit_q == 6'd1) state_q <= S_MEAN;
					end
				end
				S_MEAN: begin
					mean_q <= nm_sat;
					state_q <= S_OUT;
					bit_q <= 6'd1;
				end
				S_OUT: begin
					if (bit_q == 6'd1) begin
						rhs_q <= rhs;
						bit_q <= 6'd2;
					end else begin
						bit_q <= 6'd0;
						state_q <= S_IDLE;
						res_q.issued <= do_issue;
						res_q.new_id <= do_issue ? idc_next : '0;
						res_q.new_value <= do_issue ? it_q.sample : '0;
						res_q.status <= st_c;
						res_q.outstanding_count <= '0;
						res_q.mean_out <= '0;
						// first sample primes the mean
						if (do_prime) begin
							primed_q <= 1'b1;
							last_time_q <= it_q.time_ms;
							wsum_q <= 32'd65536;
							mean_q <= 40'(it_q.sample) <<< 16;
						end
						// new command in the lowest free slot
						if (do_issue) begin
							idc_q <= idc_next;
							sv_q[free_k] <= 1'b1;
							sid_q[free_k] <= idc_next;
						end
						// every matching slot is freed
						if (do_free) sv_q <= sv_q & ~hit;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_IMP(a_take_idle, clk, arst_n, wq_take, state_q == S_IDLE)
	`ASSERT_IMP(a_onehot, clk, arst_n, 1'b1, $onehot(state_q))
	`ASSERT_NEXT(a_res_hold, clk, arst_n, full_q && !pop, full_q && $stable(res_q))
endmodule
`default_nettype wire

[sv/dmst_out.sv]
// output stage: fills count and mean from the state after the item
`default_nettype none
module dmst_out import dmst_pkg::*; (
	input  wire out_item_t  raw,
	input  wire logic [1:0] cnt,
	input  wire logic signed [39:0] mean,
	output out_item_t       res
);
	always_comb begin
		res = raw;
		res.outstanding_count = cnt;
		res.mean_out = mean;
	end
endmodule
`default_nettype wire

[dv/testbench.sv]
// self-checking testbench of the decayed mean spike trigger
`timescale 1ns / 1ps
module testbench;
	import dmst_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 200;
	localparam int InW = $bits(in_item_t);
	localparam longint MEAN_TOP = 64'sd549755813887;
	localparam longint MEAN_BOT = -64'sd549755813888;
	localparam int unsigned HALF_STEP [17] = '{
		65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
		44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	in_item_t in_item = '0;
	logic empty;
	logic pop = 1'b0;
	out_item_t out_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = REG_ENABLE;
	logic [31:0] cfg_data = '0;

	// shadow of the block state and registers
	logic en_r;
	int unsigned ratio_r;
	int unsigned half_r;
	logic have_mean;
	logic [31:0] prev_time;
	longint mean_acc;
	longint unsigned wsum;
	logic [30:0] id_seq;
	logic slot_busy [PENDING_SLOTS];
	logic [30:0] slot_num [PENDING_SLOTS];

	out_item_t pending_outcomes [$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;

	decayed_mean_spike_trigger dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .in_item(in_item),
		.empty(empty), .pop(pop), .out_item(out_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// piecewise linear 2^(-dt/h) in q1.16
	function automatic longint unsigned decay_factor(input logic [31:0] dt);
		int unsigned h, q, r, f, i, l, d;
		h = (half_r == 0) ? 1 : half_r;
		q = dt / h;
		r = dt % h;
		f = ((longint'(r) << 16) / h) & 32'hFFFF;
		i = f >> 12;
		l = f & 32'hFFF;
		d = HALF_STEP[i] - (((HALF_STEP[i] - HALF_STEP[i + 1]) * l) >> 12);
		if (q >= 17)
			return 0;
		return d >> q;
	endfunction

	function automatic logic release_id(input logic [30:0] id);
		logic hit;
		hit = 1'b0;
		for (int k = 0; k < PENDING_SLOTS; k++) begin
			if (slot_busy[k] && slot_num[k] == id) begin
				slot_busy[k] = 1'b0;
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	function automatic logic [3:0] take_sample(input logic [31:0] t, input longint x);
		longint unsigned wn, mag, quo;
		longint diff, nm;
		int k;
		if (!have_mean) begin
			have_mean = 1'b1;
			prev_time = t;
			wsum = 65536;
			mean_acc = x * 65536;
			return ST_PRIMED;
		end
		if (t < prev_time)
			return ST_BACKWARD;
		wn = ((wsum * decay_factor(t - prev_time)) >> 16) + 65536;
		prev_time = t;
		if (wn > 64'hFFFF_FFFF)
			wn = 64'hFFFF_FFFF;
		wsum = wn;
		diff = x * 65536 - mean_acc;
		mag = (diff < 0) ? -diff : diff;
		quo = (mag << 16) / wn;
		nm = (diff < 0) ? mean_acc - longint'(quo) : mean_acc + longint'(quo);
		if (nm > MEAN_TOP)
			nm = MEAN_TOP;
		if (nm < MEAN_BOT)
			nm = MEAN_BOT;
		mean_acc = nm;
		if (x * 64'sd4294967296 < mean_acc * longint'(ratio_r))
			return ST_BELOW;
		if (!en_r)
			return ST_DISABLED;
		for (k = 0; k < PENDING_SLOTS; k++)
			if (!slot_busy[k])
				break;
		if (k >= PENDING_SLOTS)
			return ST_LIMIT;
		id_seq = id_seq + 31'd1;
		slot_busy[k] = 1'b1;
		slot_num[k] = id_seq;
		return ST_ISSUED;
	endfunction

	// expected outcome of one accepted request
	function automatic out_item_t predict_outcome(input in_item_t it);
		out_item_t o;
		int n;
		o = '0;
		case (it.opcode)
			OP_SAMPLE: begin
				o.status = take_sample(it.time_ms, longint'(it.sample));
				if (o.status == ST_ISSUED) begin
					o.issued = 1'b1;
					o.new_id = id_seq;
					o.new_value = it.sample;
				end
			end
			OP_REPORT: begin
				if (it.result_value > 0)
					o.status = ST_NOTFINAL;
				else
					o.status = release_id(it.command_id) ? ST_RELEASED : ST_UNKNOWN;
			end
			OP_CLEAR: begin
				o.status = release_id(it.command_id) ? ST_CLEARED : ST_UNKNOWN;
			end
			default: o.status = ST_UNKNOWN;
		endcase
		n = 0;
		for (int k = 0; k < PENDING_SLOTS; k++)
			n += slot_busy[k];
		o.outstanding_count = n[1:0];
		o.mean_out = mean_acc[39:0];
		return o;
	endfunction

	// one request, with random sender gaps
	task automatic send_item(input in_item_t it);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push = 1'b0;
			@(negedge clk);
		end
		push = 1'b1;
		in_item = it;
		do @(posedge clk); while (full);
		pending_outcomes.push_back(predict_outcome(it));
	endtask

	task automatic drain();
		@(negedge clk);
		push = 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
		drain();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ENABLE: en_r = data[0];
			REG_RATIO:  ratio_r = data[16:0];
			REG_HALF:   half_r = data[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic in_item_t mk(input logic [1:0] op, input logic [31:0] t,
			input logic [23:0] x, input logic [30:0] id, input logic [31:0] rv);
		in_item_t it;
		it.opcode = op;
		it.time_ms = t;
		it.sample = x;
		it.command_id = id;
		it.result_value = rv;
		return it;
	endfunction

	// pick the id of a random slot if it is outstanding, most of the time
	function automatic logic [30:0] pick_id();
		int k;
		k = $urandom_range(0, PENDING_SLOTS - 1);
		if (slot_busy[k] && $urandom_range(0, 9) < 8)
			return slot_num[k];
		return 31'($urandom);
	endfunction

	// mostly increasing samples with spikes; reports and clears mostly on live ids
	function automatic in_item_t rand_item();
		in_item_t it;
		int r, s;
		it = InW'({$urandom, $urandom, $urandom, $urandom});
		r = $urandom_range(0, 99);
		if (r < 60) begin
			it.opcode = OP_SAMPLE;
			s = $urandom_range(0, 99);
			if (s < 80)
				it.time_ms = prev_time + $urandom_range(1, 1500);
			else if (s < 87)
				it.time_ms = prev_time;
			else if (s < 93)
				it.time_ms = prev_time - $urandom_range(1, 500);
			else
				it.time_ms = prev_time + $urandom_range(0, 32'h00FF_FFFF);
			s = $urandom_range(0, 99);
			if (s < 55)
				it.sample = 24'($signed($urandom_range(0, 2000)) - 1000);
			else if (s < 85)
				it.sample = 24'($urandom_range(3000, 60000));
			else if (s < 92)
				it.sample = 24'(-$signed($urandom_range(0, 60000)));
			else
				it.sample = 24'($urandom);
		end else if (r < 80) begin
			it.opcode = OP_REPORT;
			it.command_id = pick_id();
			if ($urandom_range(0, 1))
				it.result_value = ($urandom_range(0, 3) == 0) ? 32'd0 : ($urandom | 32'h8000_0000);
		end else if (r < 95) begin
			it.opcode = OP_CLEAR;
			it.command_id = pick_id();
		end else begin
			it.opcode = OP_UNUSED;
		end
		return it;
	endfunction

	// result checker
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && pop && !empty) begin
			if (pending_outcomes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: %p", out_item);
			end else begin
				want = pending_outcomes.pop_front();
				if (out_item !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", want, out_item);
				end
			end
		end
	end

	// receiver stalls and long hold-off
	always @(negedge clk) begin
		if (hold_left > 0) begin
			pop <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			pop <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// watchdog on cycles with no handshake
	initial begin
		int idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				idle = 0;
			else
				idle++;
		end
		$display("decayed_mean_spike_trigger verification failed");
		$finish;
	end

	task automatic test_directed();
		send_item(mk(OP_REPORT, 32'hFFFF_FFFF, 24'h7FFFFF, 31'd1, 32'd0));
		send_item(mk(OP_CLEAR, 0, 0, 31'h7FFF_FFFF, 0));
		send_item(mk(OP_UNUSED, 0, 0, 0, 0));
		send_item(mk(OP_SAMPLE, 32'd100, 24'h800000, 0, 0));
		send_item(mk(OP_SAMPLE, 32'd100, 24'h7FFFFF, 0, 0));
		send_item(mk(OP_SAMPLE, 32'd50, 24'd5, 0, 0));
		send_item(mk(OP_SAMPLE, 32'd2100, 24'h7FFFFF, 0, 0));
		send_item(mk(OP_SAMPLE, 32'd2200, 24'h7FFFFF, 0, 0));
		send_item(mk(OP_REPORT, 0, 0, slot_num[0], 32'h7FFF_FFFF));
		send_item(mk(OP_REPORT, 0, 0, slot_num[0], 32'h8000_0000));
		send_item(mk(OP_REPORT, 0, 0, 31'h1234, 32'd0));
		send_item(mk(OP_CLEAR, 0, 0, slot_num[1], 0));
		send_item(mk(OP_SAMPLE, 32'd2300, 24'd0, 0, 0));
		send_item(mk(OP_SAMPLE, 32'd90_000_000, 24'h7FFFFF, 0, 0));
	endtask

	task automatic test_register_extremes();
		cfg_write(REG_ENABLE, 32'd0);
		send_item(mk(OP_SAMPLE, prev_time + 5000, 24'h7FFFFF, 0, 0));
		cfg_write(REG_ENABLE, 32'd1);
		cfg_write(REG_HALF, 32'd0);
		send_item(mk(OP_SAMPLE, prev_time + 3, 24'd1000, 0, 0));
		cfg_write(REG_HALF, 32'd65535);
		send_item(mk(OP_SAMPLE, prev_time + 40000, 24'h800000, 0, 0));
		cfg_write(REG_RATIO, 32'd0);
		send_item(mk(OP_SAMPLE, prev_time + 1, 24'd0, 0, 0));
		cfg_write(REG_RATIO, 32'd131071);
		send_item(mk(OP_SAMPLE, prev_time + 1, 24'd100, 0, 0));
		send_item(mk(OP_CLEAR, 0, 0, slot_num[0], 0));
		send_item(mk(OP_CLEAR, 0, 0, slot_num[1], 0));
	endtask

	task automatic random_phase(input int n, input int s_pct, input int r_pct);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		repeat (n) send_item(rand_item());
	endtask

	task automatic test_random();
		cfg_write(REG_RATIO, 32'd68813);
		cfg_write(REG_HALF, 32'd1000);
		random_phase(110, 0, 0);
		cfg_write(REG_HALF, 32'd1);
		cfg_write(REG_RATIO, 32'd0);
		random_phase(110, 61, 0);
		cfg_write(REG_HALF, 32'd65535);
		cfg_write(REG_RATIO, 32'd131071);
		random_phase(110, 0, 61);
		cfg_write(REG_ENABLE, 32'd0);
		cfg_write(REG_RATIO, 32'd70000);
		cfg_write(REG_HALF, 32'd300);
		random_phase(40, 8, 8);
		cfg_write(REG_ENABLE, 32'd1);
		random_phase(80, 8, 8);
	endtask

	// receiver holds off while requests keep coming
	task automatic test_backpressure();
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		@(posedge clk);
		hold_left = 400;
		repeat (8) send_item(rand_item());
	endtask

	task automatic test_time_top();
		drain();
		send_item(mk(OP_SAMPLE, 32'hFFFF_FFFF, 24'd7, 0, 0));
		send_item(mk(OP_SAMPLE, 32'd5, 24'd7, 0, 0));
		send_item(mk(OP_SAMPLE, 32'hFFFF_FFFF, 24'd9000, 0, 0));
	endtask

	initial begin
		en_r = 1'b1;
		ratio_r = 68813;
		half_r = 1000;
		have_mean = 1'b0;
		prev_time = '0;
		mean_acc = 0;
		wsum = 0;
		id_seq = '0;
		for (int k = 0; k < PENDING_SLOTS; k++) begin
			slot_busy[k] = 1'b0;
			slot_num[k] = '0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_register_extremes();
		test_random();
		test_backpressure();
		test_time_top();
		drain();
		if (mismatches == 0 && pending_outcomes.size() == 0)
			$display("decayed_mean_spike_trigger verification clean");
		else
			$display("decayed_mean_spike_trigger verification failed");
		$finish;
	end
endmodule
